@@ hdl/sbsm_pkg.sv @@
// Shared types, constants and test functions of the segment box size matcher.
package sbsm_pkg;

    localparam int ID_BITS = 12;
    localparam int COORD_BITS = 16;
    localparam int REG_BITS = 15;
    localparam int CFG_INDEX_BITS = 3;

    localparam int IN_DATA_BITS = ((3 * COORD_BITS + ID_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((1 + ID_BITS + 7) / 8) * 8;
    localparam int CMP_BITS = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 3;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    localparam logic [REG_BITS-1:0] NEAR_RESET = REG_BITS'(500);
    localparam logic [REG_BITS-1:0] FAR_RESET = REG_BITS'(1500);
    localparam logic [REG_BITS-1:0] WIDTH_RESET = REG_BITS'(300);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(500);
    localparam logic [REG_BITS-1:0] DEPTH_RESET = REG_BITS'(500);
    localparam logic [REG_BITS-1:0] TOLERANCE_RESET = REG_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CHECK_FULL    = 3'd0,
        REG_NEAR_LIMIT    = 3'd1,
        REG_FAR_LIMIT     = 3'd2,
        REG_TARGET_WIDTH  = 3'd3,
        REG_TARGET_HEIGHT = 3'd4,
        REG_TARGET_DEPTH  = 3'd5,
        REG_TOLERANCE     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                check_full;
        logic [REG_BITS-1:0] near_limit;
        logic [REG_BITS-1:0] far_limit;
        logic [REG_BITS-1:0] target_width;
        logic [REG_BITS-1:0] target_height;
        logic [REG_BITS-1:0] target_depth;
        logic [REG_BITS-1:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    function automatic logic signed [CMP_BITS-1:0] sext(logic signed [COORD_BITS-1:0] v);
        return CMP_BITS'(v);
    endfunction

    function automatic logic signed [CMP_BITS-1:0] zext(logic [REG_BITS-1:0] v);
        return $signed(CMP_BITS'(v));
    endfunction

    function automatic logic near_target(logic signed [CMP_BITS-1:0] extent,
                                         logic [REG_BITS-1:0] target,
                                         logic [REG_BITS-1:0] tol);
        logic signed [CMP_BITS-1:0] diff;
        logic signed [CMP_BITS-1:0] mag;
        diff = extent - zext(target);
        mag = (diff < 0) ? -diff : diff;
        return mag <= zext(tol);
    endfunction

    function automatic logic box_passes(box_t b, cfg_t c);
        logic signed [CMP_BITS-1:0] near_lo;
        logic signed [CMP_BITS-1:0] far_hi;
        logic window_ok;
        logic size_ok;
        near_lo = zext(c.near_limit) - zext(c.tolerance);
        far_hi = zext(c.far_limit) + zext(c.tolerance);
        window_ok = !c.check_full || !((sext(b.max_z) < near_lo) || (sext(b.min_z) > far_hi));
        size_ok = near_target(sext(b.max_x) - sext(b.min_x), c.target_width, c.tolerance)
            && near_target(sext(b.max_y) - sext(b.min_y), c.target_height, c.tolerance)
            && (!c.check_full
                || near_target(sext(b.max_z) - sext(b.min_z), c.target_depth, c.tolerance));
        return window_ok && size_ok;
    endfunction

endpackage

@@ hdl/segment_box_size_matcher.sv @@
// Top level of the segment box size matcher: input register, box update and result register.
// A last point's result is computed from the input register and loaded into the result
// register, which presents it on the master side.
// Throughput: one point per cycle; only a last point waits, and only while the result
// register still holds an untaken result.
// Reset: rst_n clears the open segment, the match record, both valid flags and
// restores every configuration register to its default; no clearing pass is needed.
module segment_box_size_matcher
    import sbsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0 up: x_mm, y_mm, z_mm, segment_id, zero fill.
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // Fields from bit 0 up: found, match_id, zero fill.
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data
);

    cfg_t cfg_reg;

    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] in_x_reg;
    logic signed [COORD_BITS-1:0] in_y_reg;
    logic signed [COORD_BITS-1:0] in_z_reg;
    logic [ID_BITS-1:0]           in_id_reg;
    logic                         in_last_reg;

    logic               segment_open_reg;
    logic               segment_open_next;
    logic [ID_BITS-1:0] open_id_reg;
    logic [ID_BITS-1:0] open_id_next;
    box_t               box_reg;
    box_t               box_next;
    logic               match_seen_reg;
    logic               match_seen_next;
    logic [ID_BITS-1:0] match_label_reg;
    logic [ID_BITS-1:0] match_label_next;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [ID_BITS-1:0] out_id_reg;

    logic               advance;
    logic               same_segment;
    logic               close_old;
    logic               old_match;
    logic               seen_mid;
    logic [ID_BITS-1:0] label_mid;
    logic               new_match;
    logic               result_found;
    logic [ID_BITS-1:0] result_id;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_full <= 1'b1;
            cfg_reg.near_limit <= NEAR_RESET;
            cfg_reg.far_limit <= FAR_RESET;
            cfg_reg.target_width <= WIDTH_RESET;
            cfg_reg.target_height <= HEIGHT_RESET;
            cfg_reg.target_depth <= DEPTH_RESET;
            cfg_reg.tolerance <= TOLERANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CHECK_FULL:    cfg_reg.check_full <= cfg_data[0];
                REG_NEAR_LIMIT:    cfg_reg.near_limit <= cfg_data;
                REG_FAR_LIMIT:     cfg_reg.far_limit <= cfg_data;
                REG_TARGET_WIDTH:  cfg_reg.target_width <= cfg_data;
                REG_TARGET_HEIGHT: cfg_reg.target_height <= cfg_data;
                REG_TARGET_DEPTH:  cfg_reg.target_depth <= cfg_data;
                REG_TOLERANCE:     cfg_reg.tolerance <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A point moves on unless it is a last point and the result register is blocked.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_x_reg <= s_axis_tdata[COORD_BITS-1:0];
            in_y_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            in_z_reg <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            in_id_reg <= s_axis_tdata[3*COORD_BITS+ID_BITS-1:3*COORD_BITS];
            in_last_reg <= s_axis_tlast;
        end
    end

    always_comb
    begin
        same_segment = segment_open_reg && (in_id_reg == open_id_reg);
        close_old = segment_open_reg && (in_id_reg != open_id_reg);
        old_match = close_old && !match_seen_reg && box_passes(box_reg, cfg_reg);
        seen_mid = match_seen_reg || old_match;
        label_mid = old_match ? open_id_reg : match_label_reg;

        if (same_segment)
        begin
            box_next.min_x = (in_x_reg < box_reg.min_x) ? in_x_reg : box_reg.min_x;
            box_next.min_y = (in_y_reg < box_reg.min_y) ? in_y_reg : box_reg.min_y;
            box_next.min_z = (in_z_reg < box_reg.min_z) ? in_z_reg : box_reg.min_z;
            box_next.max_x = (in_x_reg > box_reg.max_x) ? in_x_reg : box_reg.max_x;
            box_next.max_y = (in_y_reg > box_reg.max_y) ? in_y_reg : box_reg.max_y;
            box_next.max_z = (in_z_reg > box_reg.max_z) ? in_z_reg : box_reg.max_z;
        end
        else
        begin
            box_next.min_x = in_x_reg;
            box_next.min_y = in_y_reg;
            box_next.min_z = in_z_reg;
            box_next.max_x = in_x_reg;
            box_next.max_y = in_y_reg;
            box_next.max_z = in_z_reg;
        end

        new_match = in_last_reg && !seen_mid && box_passes(box_next, cfg_reg);
        result_found = seen_mid || new_match;
        result_id = seen_mid ? label_mid : (new_match ? in_id_reg : '0);

        if (in_last_reg)
        begin
            segment_open_next = 1'b0;
            open_id_next = '0;
            match_seen_next = 1'b0;
            match_label_next = '0;
        end
        else
        begin
            segment_open_next = 1'b1;
            open_id_next = in_id_reg;
            match_seen_next = seen_mid;
            match_label_next = label_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_open_reg <= 1'b0;
            open_id_reg <= '0;
            match_seen_reg <= 1'b0;
            match_label_reg <= '0;
        end
        else if (advance)
        begin
            segment_open_reg <= segment_open_next;
            open_id_reg <= open_id_next;
            match_seen_reg <= match_seen_next;
            match_label_reg <= match_label_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            box_reg <= box_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_found_reg <= result_found;
            out_id_reg <= result_id;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_DATA_BITS'({out_id_reg, out_found_reg});

    a_no_id_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_id_reg == '0)
        else $error("Result without a match carries a nonzero id.");

    a_cloud_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> !segment_open_reg && !match_seen_reg)
        else $error("State not cleared after the last point of a cloud.");

    a_first_match_kept: assert property (@(posedge clk) disable iff (!rst_n)
        match_seen_reg && !(advance && in_last_reg) |=> $stable(match_label_reg))
        else $error("A later segment replaced the first match.");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready)
        else $error("Input stalled without a blocked result.");

endmodule

@@ dv/match_result_checker.sv @@
// Checker for the segment box size matcher: predicts each cloud's match report and compares it.
`timescale 1ns / 100ps
module match_result_checker
    import sbsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data,
    output int                        mismatch_count,
    output int                        results_owed
);

    typedef struct packed {
        logic                found;
        logic [ID_BITS-1:0]  label;
    } match_report_t;

    match_report_t       expected_matches[$];
    cfg_t                settings;
    logic                seg_open;
    logic [ID_BITS-1:0]  seg_label;
    int                  box_lo[3];
    int                  box_hi[3];
    logic                have_match;
    logic [ID_BITS-1:0]  winner;
    int                  errors;

    function automatic void reset_box();
        for (int k = 0; k < 3; k++)
        begin
            box_lo[k] = int'(COORD_MAX);
            box_hi[k] = int'(COORD_MIN);
        end
    endfunction

    function automatic void forget_cloud();
        seg_open = 1'b0;
        seg_label = '0;
        have_match = 1'b0;
        winner = '0;
        reset_box();
    endfunction

    function automatic bit fits_target(input int extent, input logic [REG_BITS-1:0] target);
        int d;
        d = extent - int'(target);
        if (d < 0)
            d = -d;
        return d <= int'(settings.tolerance);
    endfunction

    function automatic bit segment_fits();
        int tol;
        bit ok;
        tol = int'(settings.tolerance);
        if (settings.check_full
            && (box_hi[2] < int'(settings.near_limit) - tol
                || box_lo[2] > int'(settings.far_limit) + tol))
            return 1'b0;
        ok = fits_target(box_hi[0] - box_lo[0], settings.target_width)
            && fits_target(box_hi[1] - box_lo[1], settings.target_height);
        if (settings.check_full)
            ok = ok && fits_target(box_hi[2] - box_lo[2], settings.target_depth);
        return ok;
    endfunction

    function automatic void close_segment();
        if (seg_open && !have_match && segment_fits())
        begin
            have_match = 1'b1;
            winner = seg_label;
        end
    endfunction

    function automatic void take_point(input logic [IN_DATA_BITS-1:0] word, input logic last);
        logic signed [COORD_BITS-1:0] c[3];
        logic [ID_BITS-1:0]           label;
        match_report_t                report;
        for (int k = 0; k < 3; k++)
            c[k] = word[k*COORD_BITS +: COORD_BITS];
        label = word[3*COORD_BITS +: ID_BITS];
        if (seg_open && label != seg_label)
        begin
            close_segment();
            seg_open = 1'b0;
        end
        if (!seg_open)
        begin
            reset_box();
            seg_open = 1'b1;
            seg_label = label;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (int'(c[k]) < box_lo[k])
                box_lo[k] = int'(c[k]);
            if (int'(c[k]) > box_hi[k])
                box_hi[k] = int'(c[k]);
        end
        if (last)
        begin
            close_segment();
            report.found = have_match;
            report.label = have_match ? winner : '0;
            expected_matches.insert(expected_matches.size(), report);
            forget_cloud();
        end
    endfunction

    function automatic void set_register(input logic [CFG_INDEX_BITS-1:0] index,
                                         input logic [REG_BITS-1:0] value);
        case (index)
            REG_CHECK_FULL:    settings.check_full = value[0];
            REG_NEAR_LIMIT:    settings.near_limit = value;
            REG_FAR_LIMIT:     settings.far_limit = value;
            REG_TARGET_WIDTH:  settings.target_width = value;
            REG_TARGET_HEIGHT: settings.target_height = value;
            REG_TARGET_DEPTH:  settings.target_depth = value;
            REG_TOLERANCE:     settings.tolerance = value;
            default:           ;
        endcase
    endfunction

    function automatic void compare_result(input logic [OUT_DATA_BITS-1:0] word);
        match_report_t want;
        match_report_t got;
        got.found = word[0];
        got.label = word[ID_BITS:1];
        if (expected_matches.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual found=%0d match_id=%0d",
                     $time, got.found, got.label);
            return;
        end
        want = expected_matches.pop_front();
        if (got.found !== want.found)
        begin
            errors++;
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
        end
        if (got.label !== want.label)
        begin
            errors++;
            $display("%0t: match_id mismatch, expected %0d, actual %0d",
                     $time, want.label, got.label);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings = '{1'b1, NEAR_RESET, FAR_RESET, WIDTH_RESET, HEIGHT_RESET,
                         DEPTH_RESET, TOLERANCE_RESET};
            forget_cloud();
            expected_matches.delete();
            errors = 0;
            mismatch_count <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_point(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready)
                set_register(cfg_index, cfg_data);
            mismatch_count <= errors;
            results_owed <= expected_matches.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the segment box size matcher testbench: clock, reset, point clouds and verdict.
`timescale 1ns / 100ps
module testbench;
    import sbsm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_POINTS = 155;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} sink_mode_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CHECK_FULL;
    logic [REG_BITS-1:0]       cfg_data = '0;

    int         mismatches;
    int         results_owed;
    cfg_t       cur;
    int         burst_left = 0;
    int         points_sent = 0;
    int         quiet_cycles = 0;
    sink_mode_t sink_mode = RX_OPEN;
    int         sink_left = 0;
    logic [3:0] beat = '0;
    wire        any_txn = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                          || (cfg_valid && cfg_ready);

    segment_box_size_matcher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    match_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        beat <= beat + 1'b1;
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= beat[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || any_txn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int aim_extent(input logic [REG_BITS-1:0] target);
        int tol;
        int d;
        tol = int'(cur.tolerance);
        case ($urandom_range(0, 2))
            0:       d = tol;
            1:       d = tol + 1;
            default: d = int'($urandom_range(0, tol + 2));
        endcase
        return clamp($urandom_range(0, 1) ? int'(target) + d : int'(target) - d, 0, 65535);
    endfunction

    function automatic logic [REG_BITS-1:0] spread(input int typical);
        return ($urandom_range(0, 4) == 0) ? REG_BITS'($urandom_range(0, 32767))
                                           : REG_BITS'($urandom_range(0, typical));
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.check_full = 1'($urandom_range(0, 1));
        s.near_limit = spread(2000);
        s.far_limit = spread(4000);
        s.target_width = spread(1500);
        s.target_height = spread(1500);
        s.target_depth = spread(1500);
        s.tolerance = spread(300);
        return s;
    endfunction

    task automatic send_point(input int x, input int y, input int z,
                              input int label, input bit last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_BITS'({ID_BITS'(label), COORD_BITS'(z), COORD_BITS'(y),
                                       COORD_BITS'(x)});
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [REG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_settings(input cfg_t s);
        logic [REG_BITS-2:0] junk;
        junk = (REG_BITS - 1)'($urandom);
        put_reg(REG_CHECK_FULL, {junk, s.check_full});
        put_reg(REG_NEAR_LIMIT, s.near_limit);
        put_reg(REG_FAR_LIMIT, s.far_limit);
        put_reg(REG_TARGET_WIDTH, s.target_width);
        put_reg(REG_TARGET_HEIGHT, s.target_height);
        put_reg(REG_TARGET_DEPTH, s.target_depth);
        put_reg(REG_TOLERANCE, s.tolerance);
        put_reg(REG_UNUSED, REG_BITS'($urandom));
        cfg_valid <= 1'b0;
        cur = s;
    endtask

    task automatic send_segment(input logic [ID_BITS-1:0] label, input bit aimed,
                                input bit closes);
        int count;
        int lo_at;
        int hi_at;
        int anchor;
        int slack;
        int ext[3];
        int base[3];
        int pt[3];
        count = $urandom_range(1, 6);
        if (aimed)
        begin
            ext[0] = aim_extent(cur.target_width);
            ext[1] = aim_extent(cur.target_height);
            ext[2] = aim_extent(cur.target_depth);
        end
        else
            for (int k = 0; k < 3; k++)
                ext[k] = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
        for (int k = 0; k < 3; k++)
            base[k] = int'($urandom_range(0, 65535 - ext[k])) - 32768;
        if (aimed)
        begin
            slack = int'(cur.tolerance) + 3;
            anchor = $urandom_range(0, 1) ? int'(cur.near_limit) : int'(cur.far_limit);
            case ($urandom_range(0, 3))
                0:       base[2] = int'(cur.near_limit) - int'(cur.tolerance) - ext[2]
                                   - int'($urandom_range(0, 1));
                1:       base[2] = int'(cur.far_limit) + int'(cur.tolerance)
                                   + int'($urandom_range(0, 1));
                default: base[2] = anchor - int'($urandom_range(0, ext[2]))
                                   + int'($urandom_range(0, 2 * slack)) - slack;
            endcase
            base[2] = clamp(base[2], -32768, 32767 - ext[2]);
        end
        lo_at = $urandom_range(0, count - 1);
        hi_at = (count == 1) ? lo_at : (lo_at + 1 + $urandom_range(0, count - 2)) % count;
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 3; k++)
                pt[k] = (i == lo_at) ? base[k]
                      : (i == hi_at) ? base[k] + ext[k]
                      : base[k] + int'($urandom_range(0, ext[k]));
            send_point(pt[0], pt[1], pt[2], int'(label), closes && i == count - 1);
        end
    endtask

    task automatic send_cloud();
        int                 segments;
        bit                 noisy;
        logic [ID_BITS-1:0] label;
        segments = $urandom_range(1, 5);
        noisy = ($urandom_range(0, 7) == 0);
        label = '0;
        for (int s = 0; s < segments; s++)
        begin
            if (s == 0 || $urandom_range(0, 5) != 0)
                label = ID_BITS'($urandom_range(0, 4095));
            if (noisy)
                send_point(int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768, int'(label),
                           s == segments - 1);
            else
                send_segment(label, $urandom_range(0, 3) != 0, s == segments - 1);
        end
    endtask

    initial
    begin
        cfg_t plan;
        int   first_point;
        cur = '{1'b1, NEAR_RESET, FAR_RESET, WIDTH_RESET, HEIGHT_RESET, DEPTH_RESET,
                TOLERANCE_RESET};
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Extreme box, then a match that a later fitting segment must not replace.
        send_point(-32768, -32768, -32768, 7, 1'b0);
        send_point(32767, 32767, 32767, 7, 1'b0);
        send_point(0, 0, 600, 4095, 1'b0);
        send_point(300, 500, 1100, 4095, 1'b0);
        send_point(0, 0, 600, 0, 1'b0);
        send_point(250, 450, 1050, 0, 1'b0);
        send_point(10, 10, 10, 9, 1'b1);
        // Boxes entirely in front of and behind the window, then one touching its near edge.
        send_point(0, 0, -1000, 1, 1'b0);
        send_point(300, 500, -500, 1, 1'b0);
        send_point(0, 0, 2000, 2, 1'b0);
        send_point(300, 500, 2500, 2, 1'b0);
        send_point(0, 0, -100, 4, 1'b0);
        send_point(400, 600, 400, 4, 1'b1);
        // A cloud of one point finds nothing.
        send_point(150, -250, 1000, 4095, 1'b1);
        // One past the far edge is rejected, exactly on it is accepted.
        send_point(0, 0, 1601, 6, 1'b0);
        send_point(300, 500, 2101, 6, 1'b0);
        send_point(0, 0, 1600, 5, 1'b0);
        send_point(200, 400, 2000, 5, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                    plan = '{1'b1, NEAR_RESET, FAR_RESET, WIDTH_RESET, HEIGHT_RESET,
                             DEPTH_RESET, TOLERANCE_RESET};
                1:
                    plan = '0;
                2:
                    plan = '{1'b1, '1, '1, '1, '1, '1, '1};
                3:
                begin
                    plan = random_settings();
                    plan.check_full = 1'b1;
                    plan.near_limit = REG_BITS'($urandom_range(1500, 3000));
                    plan.far_limit = REG_BITS'($urandom_range(0, 1000));
                    plan.target_width = REG_BITS'(600);
                    plan.target_height = REG_BITS'(1000);
                    plan.tolerance = REG_BITS'($urandom_range(0, 200));
                end
                default:
                    plan = random_settings();
            endcase
            write_settings(plan);
            first_point = points_sent;
            while (points_sent - first_point < PHASE_POINTS)
            begin
                send_cloud();
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
            drain();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
